// ===== rtl/transitive_closure_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Transitive closure engine assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef TRANSITIVE_CLOSURE_ENGINE_DEFINES_SVH
`define TRANSITIVE_CLOSURE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define TCE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("transitive closure engine assertion failed");
`define TCE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("transitive closure engine assertion failed");
`else
`define TCE_ASSERT_IMP(lbl, ante, cons)
`define TCE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/tce_pkg.sv =====
// ----------------------------------------------------------------------------
// Transitive closure engine package
// Shared widths, constants and types of the closure engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

    localparam int ROW_W         = 32;
    localparam int ROW_SLOTS     = 32;
    localparam int IDX_OUT_W     = 5;
    localparam int NV_W          = 6;
    localparam int MAX_VERTS_DEF = 32;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int M_TDATA_W     = 40;

    localparam logic [NV_W-1:0] NUM_VERTS_RESET = 6'd32;
    localparam logic            REG_NUM_VERTS   = 1'b0;

    typedef struct packed {
        logic wr_en;
        logic clear;
    } tce_mem_ctrl_t;

    function automatic logic [ROW_W-1:0] row_mask(input logic [NV_W-1:0] n);
        return {ROW_W{1'b1}} >> (NV_W'(ROW_W) - n);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tce_row_store.sv =====
// ----------------------------------------------------------------------------
// Transitive closure engine row store
// Row memory with one write and one registered read port; per-row valid bits
// make unwritten rows read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_row_store #(
    parameter int ROWS  = 32,
    parameter int IDX_W = 5
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tce_pkg::tce_mem_ctrl_t      ctrl,
    input  wire logic [IDX_W-1:0]            waddr,
    input  wire logic [tce_pkg::ROW_W-1:0]   wdata,
    input  wire logic [IDX_W-1:0]            raddr,
    output logic      [tce_pkg::ROW_W-1:0]   rdata
);
    import tce_pkg::*;

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROWS-1:0]  valid_reg;
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[raddr];
            if (ctrl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctrl.wr_en)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/transitive_closure_engine.sv =====
// Sequence: a row without tlast is written to the row store as it is accepted.
// After the last row, the closure runs one pivot read, one pivot latch and N row
// updates per pivot, and the closed rows are then read out in order.
// Throughput: N result rows at one per cycle, unless m_tready stalls, through the single read port.
// Reset: rst_n clears the matrix valid bits, counters and num_verts (to 32).
// ----------------------------------------------------------------------------
// Transitive closure engine
// Warshall closure of a row-loaded adjacency matrix with a shared row unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "transitive_closure_engine_defines.svh"

module transitive_closure_engine #(
    parameter int MAX_VERTS = tce_pkg::MAX_VERTS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // s_tdata: row_bits[31:0]
    input  wire logic [tce_pkg::ROW_W-1:0]        s_tdata,
    input  wire logic                             s_tlast,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // m_tdata: closure_bits[31:0], out_row_index[36:32], zero pad[39:37]
    output logic [tce_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tce_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [tce_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [tce_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready
);
    import tce_pkg::*;

    localparam int ROWS  = (MAX_VERTS < ROW_SLOTS) ? MAX_VERTS : ROW_SLOTS;
    localparam int IDX_W = $clog2(ROWS);
    localparam int CNT_W = $clog2(ROWS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PIV  = 3'd1;
    localparam logic [2:0] S_PLAT = 3'd2;
    localparam logic [2:0] S_ROW  = 3'd3;
    localparam logic [2:0] S_ORD  = 3'd4;
    localparam logic [2:0] S_OLD  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [NV_W-1:0]  num_verts_reg;
    logic [ROW_W-1:0] pivot_reg, pivot_next;
    logic             m_valid_reg, m_valid_next;
    logic [ROW_W-1:0] m_data_reg;
    logic [IDX_OUT_W-1:0] m_idx_reg;
    logic             m_last_reg;

    logic [CNT_W-1:0] n_act;
    logic [IDX_W-1:0] last_idx;
    logic [ROW_W-1:0] mask;
    logic             s_fire;
    logic             out_load;
    logic             cfg_wr;

    tce_mem_ctrl_t    mem_ctrl;
    logic [IDX_W-1:0] mem_waddr;
    logic [ROW_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [ROW_W-1:0] rd_row;

    always_comb
    begin
        if (num_verts_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (num_verts_reg > NV_W'(ROWS))
        begin
            n_act = CNT_W'(ROWS);
        end
        else
        begin
            n_act = CNT_W'(num_verts_reg);
        end
    end

    assign last_idx = IDX_W'(n_act - 1'b1);
    assign mask     = row_mask(NV_W'(n_act));
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OLD) && (!m_valid_reg || m_tready);

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NUM_VERTS);
    assign prdata = (paddr[2] == REG_NUM_VERTS) ?
                    {{(APB_DATA_W-NV_W){1'b0}}, num_verts_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_verts_reg <= NUM_VERTS_RESET;
        end
        else if (cfg_wr)
        begin
            num_verts_reg <= pwdata[NV_W-1:0];
        end
    end

    tce_row_store #(
        .ROWS  (ROWS),
        .IDX_W (IDX_W)
    ) u_row_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mem_ctrl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_row)
    );

    always_comb
    begin
        mem_ctrl       = '0;
        mem_waddr      = i_reg;
        mem_wdata      = rd_row | pivot_reg;
        mem_raddr      = i_reg;
        state_next     = state_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        count_next     = count_reg;
        pivot_next     = pivot_reg;
        m_valid_next   = m_tready ? 1'b0 : m_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    if (count_reg < n_act)
                    begin
                        mem_ctrl.wr_en = 1'b1;
                        mem_waddr      = IDX_W'(count_reg);
                        mem_wdata      = s_tdata & mask;
                        count_next     = count_reg + 1'b1;
                    end
                    if (s_tlast)
                    begin
                        k_next     = '0;
                        state_next = S_PIV;
                    end
                end
            end
            S_PIV:
            begin
                mem_raddr  = k_reg;
                i_next     = '0;
                state_next = S_PLAT;
            end
            S_PLAT:
            begin
                mem_raddr  = i_reg;
                pivot_next = rd_row & mask;
                state_next = S_ROW;
            end
            S_ROW:
            begin
                mem_ctrl.wr_en = rd_row[k_reg];
                if (i_reg == last_idx)
                begin
                    mem_raddr = i_reg;
                    i_next    = '0;
                    if (k_reg == last_idx)
                    begin
                        state_next = S_ORD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_PIV;
                    end
                end
                else
                begin
                    mem_raddr = i_reg + 1'b1;
                    i_next    = i_reg + 1'b1;
                end
            end
            S_ORD:
            begin
                mem_raddr  = '0;
                state_next = S_OLD;
            end
            S_OLD:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    if (i_reg == last_idx)
                    begin
                        mem_ctrl.clear = 1'b1;
                        count_next     = '0;
                        k_next         = '0;
                        i_next         = '0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        mem_raddr = i_reg + 1'b1;
                        i_next    = i_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            i_reg       <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            i_reg       <= i_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pivot_reg <= pivot_next;
        if (out_load)
        begin
            m_data_reg <= rd_row & mask;
            m_idx_reg  <= IDX_OUT_W'(i_reg);
            m_last_reg <= (i_reg == last_idx);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W-ROW_W-IDX_OUT_W){1'b0}}, m_idx_reg, m_data_reg};

    `TCE_ASSERT_IMP(a_row_idx_range, ((state_reg == S_ROW) || (state_reg == S_OLD)), (i_reg <= last_idx))
    `TCE_ASSERT_IMP(a_pivot_range, (state_reg == S_ROW), (k_reg <= last_idx))
    `TCE_ASSERT_NXT(a_done_clears, (out_load && (i_reg == last_idx)), ((state_reg == S_IDLE) && (count_reg == '0)))

endmodule

`default_nettype wire

// ===== sim/transitive_closure_engine_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Transitive closure engine checker
// Tracks the vertex count written over APB and predicts the closed rows from
// every accepted row request. Each emitted row is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module transitive_closure_engine_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [tce_pkg::ROW_W-1:0]      s_tdata,
    input  wire logic                           s_tlast,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [tce_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                           m_tlast,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tce_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [tce_pkg::APB_DATA_W-1:0] pwdata,
    input  wire logic                           pready,
    output int                                  mismatches,
    output int                                  rows_pending,
    output int                                  rows_checked,
    output int                                  matrices_closed
);
    import tce_pkg::*;

    localparam logic [APB_ADDR_W-1:0] NUM_VERTS_ADDR = APB_ADDR_W'(4 * REG_NUM_VERTS);

    typedef struct packed {
        logic [ROW_W-1:0]     bits;
        logic [IDX_OUT_W-1:0] index;
        logic                 last;
    } closure_row_t;

    logic [ROW_W-1:0] adj_rows [ROW_SLOTS];
    logic [NV_W-1:0]  vert_count_reg;
    int               rows_loaded;
    closure_row_t     expected_rows [$];

    function automatic int active_vertices(input logic [NV_W-1:0] reg_value);
        int n;
        n = reg_value;
        if (n == 0)
            n = 1;
        if (n > MAX_VERTS_DEF)
            n = MAX_VERTS_DEF;
        return n;
    endfunction

    function automatic logic [ROW_W-1:0] vertex_mask(input int n);
        if (n >= ROW_W)
            return '1;
        return (ROW_W'(1) << n) - ROW_W'(1);
    endfunction

    task automatic store_and_close(input logic [ROW_W-1:0] bits, input logic last);
        int               n;
        logic [ROW_W-1:0] mask;
        closure_row_t     row;
        n = active_vertices(vert_count_reg);
        mask = vertex_mask(n);
        if (rows_loaded < n)
        begin
            adj_rows[rows_loaded] = bits & mask;
            rows_loaded++;
        end
        if (last)
        begin
            for (int k = 0; k < n; k++)
                for (int i = 0; i < n; i++)
                    if (adj_rows[i][k])
                        adj_rows[i] |= adj_rows[k] & mask;
            for (int i = 0; i < n; i++)
            begin
                row.bits  = adj_rows[i] & mask;
                row.index = IDX_OUT_W'(i);
                row.last  = (i == n - 1);
                expected_rows.push_back(row);
            end
            foreach (adj_rows[i])
                adj_rows[i] = '0;
            rows_loaded = 0;
            matrices_closed++;
        end
    endtask

    task automatic check_row(input logic [M_TDATA_W-1:0] data, input logic last);
        closure_row_t got;
        closure_row_t want;
        got.bits  = data[ROW_W-1:0];
        got.index = data[ROW_W +: IDX_OUT_W];
        got.last  = last;
        if (expected_rows.size() == 0)
        begin
            $display("%0t: unexpected closed row, expected none, actual bits %h index %0d last %0b",
                     $time, got.bits, got.index, got.last);
            mismatches++;
        end
        else
        begin
            want = expected_rows.pop_front();
            rows_checked++;
            if (got.bits !== want.bits)
            begin
                $display("%0t: row %0d closure bits mismatch, expected %h actual %h",
                         $time, want.index, want.bits, got.bits);
                mismatches++;
            end
            if (got.index !== want.index)
            begin
                $display("%0t: row index mismatch, expected %0d actual %0d",
                         $time, want.index, got.index);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: row %0d last flag mismatch, expected %0b actual %0b",
                         $time, want.index, want.last, got.last);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (adj_rows[i])
                adj_rows[i] = '0;
            vert_count_reg = NUM_VERTS_RESET;
            rows_loaded = 0;
            expected_rows.delete();
            rows_pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == NUM_VERTS_ADDR)
                vert_count_reg = pwdata[NV_W-1:0];
            if (m_tvalid && m_tready)
                check_row(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                store_and_close(s_tdata, s_tlast);
            rows_pending = expected_rows.size();
        end
    end

endmodule

// ===== sim/transitive_closure_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Transitive closure engine testbench
// Loads adjacency matrices row by row under several vertex counts, with
// random gaps on the request side and random stalls on the result side, and
// lets the checker compare every closed row with its own prediction.
// ----------------------------------------------------------------------------
module transitive_closure_engine_tb;

    import tce_pkg::*;

    localparam logic [APB_ADDR_W-1:0] NUM_VERTS_ADDR = APB_ADDR_W'(4 * REG_NUM_VERTS);
    localparam int RANDOM_REQUESTS = 80;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    // s_tdata: row_bits[31:0]
    logic [ROW_W-1:0]      s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // m_tdata: closure_bits[31:0], out_row_index[36:32], zero pad[39:37]
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int rows_pending;
    int rows_checked;
    int matrices_closed;
    int requests_sent = 0;
    int send_idle_pct = 29;
    int take_idle_pct = 64;

    transitive_closure_engine i_dut (.*);

    transitive_closure_engine_checker i_checker (.*);

    always #10 clk = ~clk;

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= take_idle_pct);

    initial
    begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int effective_count(input logic [NV_W-1:0] value);
        if (value == 0)
            return 1;
        if (value > MAX_VERTS_DEF)
            return MAX_VERTS_DEF;
        return value;
    endfunction

    function automatic logic [ROW_W-1:0] random_row(input int style, input int n);
        case (style)
            0:       return $urandom & $urandom & $urandom;
            1:       return ROW_W'(1) << $urandom_range(n - 1);
            2:       return $urandom;
            default: return $urandom & $urandom;
        endcase
    endfunction

    task automatic set_idle_phase();
        if (requests_sent < 45)
        begin
            send_idle_pct = 29;
            take_idle_pct = 64;
        end
        else if (requests_sent < 85)
        begin
            send_idle_pct = 64;
            take_idle_pct = 29;
        end
        else
        begin
            send_idle_pct = 0;
            take_idle_pct = 0;
        end
    endtask

    task automatic send_request(input logic [ROW_W-1:0] bits, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata  = bits;
        s_tlast  = last;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        requests_sent++;
    endtask

    // The sender holds off until every predicted row has come back.
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (rows_pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_num_verts(input logic [NV_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = NUM_VERTS_ADDR;
        pwdata  = APB_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic random_matrix(inout logic [NV_W-1:0] vert_count);
        int count;
        int rows;
        int style;
        int pick;
        count = effective_count(vert_count);
        pick = $urandom_range(99);
        if (pick < 75)
            rows = count;
        else if (pick < 90)
            rows = $urandom_range(count, 1);
        else
            rows = count + $urandom_range(3, 1);
        style = $urandom_range(3);
        for (int r = 0; r < rows; r++)
        begin
            if (r > 0 && $urandom_range(99) < 5)
            begin
                wait_idle();
                vert_count = NV_W'($urandom_range(MAX_VERTS_DEF, 1));
                write_num_verts(vert_count);
                count = effective_count(vert_count);
            end
            send_request(random_row(style, count), r == rows - 1);
        end
    endtask

    initial
    begin
        logic [NV_W-1:0] vert_count;
        int              random_goal;
        int              pick;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset vertex count, one full row and every other row missing.
        send_request('1, 1'b1);
        wait_idle();

        // A zero vertex count acts as a single vertex.
        write_num_verts(NV_W'(0));
        send_request('1, 1'b1);
        wait_idle();

        // The largest count saturates to the row width.
        write_num_verts('1);
        send_request(32'h8000_0001, 1'b0);
        send_request(32'h0000_0000, 1'b1);
        wait_idle();

        // Four vertex ring with bits above the count that must be cleared.
        write_num_verts(NV_W'(4));
        send_request(32'h0000_0002, 1'b0);
        send_request(32'h0000_0004, 1'b0);
        send_request(32'h0000_0008, 1'b0);
        send_request(32'hFFFF_FFF1, 1'b1);
        wait_idle();

        // Surplus last row is dropped but still starts the closure.
        write_num_verts(NV_W'(2));
        send_request(32'h0000_0002, 1'b0);
        send_request(32'h0000_0001, 1'b0);
        send_request(32'h0000_0003, 1'b1);
        wait_idle();

        // Count shrinks in the middle of a load.
        write_num_verts(NV_W'(8));
        send_request(32'h0000_0002, 1'b0);
        send_request(32'h0000_0004, 1'b0);
        send_request(32'h0000_0080, 1'b0);
        send_request(32'h0000_0001, 1'b0);
        send_request(32'h0000_0010, 1'b0);
        wait_idle();
        write_num_verts(NV_W'(3));
        send_request(32'h0000_0005, 1'b1);
        wait_idle();

        write_num_verts(NV_W'(33));
        send_request(32'h0000_0000, 1'b1);
        wait_idle();

        write_num_verts(NV_W'(1));
        send_request(32'h0000_0000, 1'b1);
        wait_idle();

        vert_count  = NV_W'(1);
        random_goal = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < random_goal)
        begin
            set_idle_phase();
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                wait_idle();
                pick = $urandom_range(99);
                if (pick < 80)
                    vert_count = NV_W'($urandom_range(8, 1));
                else if (pick < 92)
                    vert_count = NV_W'($urandom_range(MAX_VERTS_DEF, 9));
                else if (pick < 96)
                    vert_count = NV_W'(0);
                else
                    vert_count = NV_W'($urandom_range(63, MAX_VERTS_DEF + 1));
                write_num_verts(vert_count);
            end
            random_matrix(vert_count);
        end

        wait_idle();
        repeat (40) @(negedge clk);

        $display("Closed %0d matrices from %0d row requests and checked %0d rows.",
                 matrices_closed, requests_sent, rows_checked);
        $display("Vertex counts ran from zero to saturation, with short, long and resized loads.");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tce_pkg.sv
rtl/tce_row_store.sv
rtl/transitive_closure_engine.sv
sim/transitive_closure_engine_checker.sv
sim/transitive_closure_engine_tb.sv
